@@ rtl/throttle_motor_drive_sequencer_top_macros.svh @@
// Assertion macros for the throttle motor drive sequencer.
// Included by files that check their own logic; expects clk and rst_n in scope.
`ifndef THROTTLE_MOTOR_DRIVE_SEQUENCER_TOP_MACROS_SVH
`define THROTTLE_MOTOR_DRIVE_SEQUENCER_TOP_MACROS_SVH

// Check an implication in the same cycle.
`define TMDS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define TMDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmds_pkg.sv @@
// Shared types and constants for the throttle motor drive sequencer.
// No dependencies; used by tmds_step and the top level.
`default_nettype none

package tmds_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned StopW   = 11;
  localparam int unsigned ModeW   = 3;

  localparam logic [SampleW-1:0] FULL_SCALE = 12'hFFF;

  // Drive modes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_MOD  = 2'd1;
  localparam logic [1:0] DRV_FULL = 2'd2;

  // Mode codes as reported on the result channel
  localparam logic [ModeW-1:0] MODE_CODE_OFF      = 3'd0;
  localparam logic [ModeW-1:0] MODE_CODE_STARTING = 3'd1;
  localparam logic [ModeW-1:0] MODE_CODE_BLINK    = 3'd2;
  localparam logic [ModeW-1:0] MODE_CODE_ARMED    = 3'd3;
  localparam logic [ModeW-1:0] MODE_CODE_FORWARD  = 3'd4;
  localparam logic [ModeW-1:0] MODE_CODE_REVERSE  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_STOP_LIMIT = 1'b0;
  localparam logic CFG_ARM_LIMIT  = 1'b1;

  typedef enum logic [5:0] {
    MODE_OFF      = 6'b000001,
    MODE_STARTING = 6'b000010,
    MODE_BLINK    = 6'b000100,
    MODE_ARMED    = 6'b001000,
    MODE_FORWARD  = 6'b010000,
    MODE_REVERSE  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic               led_front;
    logic               led_back;
    logic               switch_front;
    logic               switch_back;
    logic [1:0]         drive_front_mode;
    logic [1:0]         drive_back_mode;
    logic [SampleW-1:0] duty_level;
    logic [SampleW-1:0] duty_complement;
    logic [ModeW-1:0]   mode_now;
  } result_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    c = MODE_CODE_OFF;
    unique case (m)
      MODE_OFF:      c = MODE_CODE_OFF;
      MODE_STARTING: c = MODE_CODE_STARTING;
      MODE_BLINK:    c = MODE_CODE_BLINK;
      MODE_ARMED:    c = MODE_CODE_ARMED;
      MODE_FORWARD:  c = MODE_CODE_FORWARD;
      MODE_REVERSE:  c = MODE_CODE_REVERSE;
      default:       c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tmds_step.sv @@
// Per-tick band logic, reverse latch and arming sequencer with its state registers.
// Depends on tmds_pkg; produces the result of the tick being transferred.
`default_nettype none

module tmds_step (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           fire,
  input  wire logic [tmds_pkg::SampleW-1:0]   throttle_sample,
  input  wire logic                           reverse_switch,
  input  wire logic [tmds_pkg::StopW-1:0]     stop_limit,
  input  wire logic [tmds_pkg::SampleW-1:0]   arm_limit,
  output tmds_pkg::result_t                   res
);

  tmds_pkg::mode_t             mode_r, mode_nxt;
  logic                        stopped_r, stopped_nxt;
  logic                        full_r, full_nxt;
  logic                        rev_r, rev_nxt;
  logic [tmds_pkg::SampleW-1:0] duty_r, duty_nxt;
  logic [1:0]                  lamp_r, lamp_nxt;
  logic [1:0]                  fet_r, fet_nxt;
  logic [1:0]                  front_r, front_nxt;
  logic [1:0]                  back_r, back_nxt;

  logic [tmds_pkg::SampleW-1:0] stop_ext;
  logic                         run_mode;

  assign stop_ext = {1'b0, stop_limit};
  assign run_mode = (mode_r == tmds_pkg::MODE_FORWARD) || (mode_r == tmds_pkg::MODE_REVERSE);

  always_comb begin
    mode_nxt    = mode_r;
    stopped_nxt = stopped_r;
    full_nxt    = full_r;
    duty_nxt    = duty_r;
    lamp_nxt    = lamp_r;
    fet_nxt     = fet_r;
    front_nxt   = front_r;
    back_nxt    = back_r;

    // Band logic, on the previous latch and mode
    if (throttle_sample < stop_ext) begin
      if (!stopped_r) begin
        stopped_nxt = 1'b1;
        full_nxt    = 1'b0;
        front_nxt   = tmds_pkg::DRV_STOP;
        back_nxt    = tmds_pkg::DRV_STOP;
      end
    end else if ((tmds_pkg::FULL_SCALE - throttle_sample) < stop_ext) begin
      if (!full_r && run_mode) begin
        full_nxt = 1'b1;
        if (rev_r) begin
          back_nxt = tmds_pkg::DRV_FULL;
        end else begin
          front_nxt = tmds_pkg::DRV_FULL;
        end
      end
    end else begin
      if (stopped_r || full_r) begin
        if (rev_r) begin
          back_nxt = tmds_pkg::DRV_MOD;
        end else begin
          front_nxt = tmds_pkg::DRV_MOD;
        end
      end
      stopped_nxt = 1'b0;
      full_nxt    = 1'b0;
      duty_nxt    = throttle_sample;
    end

    rev_nxt = reverse_switch;

    // Sequencer on the new sample and latch
    unique case (mode_r)
      tmds_pkg::MODE_STARTING: begin
        mode_nxt = (throttle_sample < arm_limit) ? tmds_pkg::MODE_ARMED : tmds_pkg::MODE_BLINK;
        lamp_nxt = 2'b00;
      end
      tmds_pkg::MODE_ARMED: begin
        if (rev_nxt) begin
          mode_nxt  = tmds_pkg::MODE_REVERSE;
          lamp_nxt  = 2'b10;
          fet_nxt   = 2'b10;
          front_nxt = tmds_pkg::DRV_STOP;
          back_nxt  = tmds_pkg::DRV_MOD;
        end else begin
          mode_nxt  = tmds_pkg::MODE_FORWARD;
          lamp_nxt  = 2'b01;
          fet_nxt   = 2'b01;
          front_nxt = tmds_pkg::DRV_MOD;
          back_nxt  = tmds_pkg::DRV_STOP;
        end
      end
      tmds_pkg::MODE_FORWARD: begin
        if (rev_nxt) begin
          mode_nxt  = tmds_pkg::MODE_STARTING;
          lamp_nxt  = 2'b11;
          fet_nxt   = 2'b00;
          front_nxt = tmds_pkg::DRV_STOP;
          back_nxt  = tmds_pkg::DRV_STOP;
        end
      end
      tmds_pkg::MODE_REVERSE: begin
        if (!rev_nxt) begin
          mode_nxt  = tmds_pkg::MODE_STARTING;
          lamp_nxt  = 2'b11;
          fet_nxt   = 2'b00;
          front_nxt = tmds_pkg::DRV_STOP;
          back_nxt  = tmds_pkg::DRV_STOP;
        end
      end
      default: begin
        // off and blink both go to starting
        mode_nxt  = tmds_pkg::MODE_STARTING;
        lamp_nxt  = 2'b11;
        fet_nxt   = 2'b00;
        front_nxt = tmds_pkg::DRV_STOP;
        back_nxt  = tmds_pkg::DRV_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tmds_pkg::MODE_OFF;
      stopped_r <= 1'b0;
      full_r    <= 1'b0;
      rev_r     <= 1'b0;
      duty_r    <= '0;
      lamp_r    <= 2'b00;
      fet_r     <= 2'b00;
      front_r   <= tmds_pkg::DRV_STOP;
      back_r    <= tmds_pkg::DRV_STOP;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      stopped_r <= stopped_nxt;
      full_r    <= full_nxt;
      rev_r     <= rev_nxt;
      duty_r    <= duty_nxt;
      lamp_r    <= lamp_nxt;
      fet_r     <= fet_nxt;
      front_r   <= front_nxt;
      back_r    <= back_nxt;
    end
  end

  always_comb begin
    res.led_front        = lamp_nxt[0];
    res.led_back         = lamp_nxt[1];
    res.switch_front     = fet_nxt[0];
    res.switch_back      = fet_nxt[1];
    res.drive_front_mode = front_nxt;
    res.drive_back_mode  = back_nxt;
    res.duty_level       = duty_nxt;
    res.duty_complement  = tmds_pkg::FULL_SCALE - duty_nxt;
    res.mode_now         = tmds_pkg::mode_code(mode_nxt);
  end

endmodule

`default_nettype wire

@@ rtl/throttle_motor_drive_sequencer_top.sv @@
// Throttle motor drive sequencer: configuration registers, tick logic and output skid.
// Depends on tmds_pkg, tmds_step and throttle_motor_drive_sequencer_top_macros.svh.
//
// Usage:
//   Each transfer on the in_ channel is one control tick: a 12-bit throttle
//   sample and the reverse switch level. Each tick yields exactly one transfer
//   on the out_ channel carrying LEDs, MOSFET enables, both drive modes, the
//   duty value and its complement, and the current arming mode.
//   The result is registered in the output register, or in the skid register
//   if the receiver stalls. Throughput: one tick per clock while the receiver
//   keeps out_tready high.
//   The state is updated in the cycle a tick is transferred, so a tick sees
//   everything the previous tick left behind with no gap between them.
//   When the receiver stalls, a second result goes into a skid register;
//   in_tready drops only once both the output and skid registers are full.
//   Results leave in order, none dropped.
//   Reset (rst_n low, synchronous) puts the sequencer in off with both drives
//   stopped, clears both result valid flags, and loads stop_limit = 204 and
//   arm_limit = 2047. Write cfg_ registers only while no tick is in flight.
`default_nettype none

`include "throttle_motor_drive_sequencer_top_macros.svh"

module throttle_motor_drive_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata: [11:0] throttle_sample, [12] reverse_switch, [15:13] zero
  input  wire logic [15:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [0] led_front, [1] led_back, [2] switch_front, [3] switch_back,
  //   [5:4] drive_front_mode, [7:6] drive_back_mode, [19:8] duty_level,
  //   [31:20] duty_complement, [34:32] mode_now, [39:35] zero
  output logic [39:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [11:0] cfg_wdata
);

  logic [tmds_pkg::StopW-1:0]   stop_limit_r;
  logic [tmds_pkg::SampleW-1:0] arm_limit_r;

  tmds_pkg::result_t res;
  tmds_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_fire, out_fire;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_limit_r <= 11'd204;
      arm_limit_r  <= 12'd2047;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tmds_pkg::CFG_STOP_LIMIT: stop_limit_r <= cfg_wdata[tmds_pkg::StopW-1:0];
        tmds_pkg::CFG_ARM_LIMIT:  arm_limit_r  <= cfg_wdata;
        default:                  stop_limit_r <= stop_limit_r;
      endcase
    end
  end

  // Tick logic; advance state on each input transfer
  tmds_step u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (in_fire),
    .throttle_sample (in_tdata[11:0]),
    .reverse_switch  (in_tdata[12]),
    .stop_limit      (stop_limit_r),
    .arm_limit       (arm_limit_r),
    .res             (res)
  );

  // Output register with skid: refill from skid first, otherwise take the new result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && !out_tready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0,
                       out_r.mode_now,
                       out_r.duty_complement,
                       out_r.duty_level,
                       out_r.drive_back_mode,
                       out_r.drive_front_mode,
                       out_r.switch_back,
                       out_r.switch_front,
                       out_r.led_back,
                       out_r.led_front};

  `TMDS_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid holds data with output empty")
  `TMDS_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid_r && !out_tready, skid_valid_r, "stalled result not kept in skid")
  `TMDS_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_tready, out_valid_r && !skid_valid_r, "skid did not move to output")
  `TMDS_ASSERT_NOW(a_forward_no_back, out_valid_r && out_r.mode_now == tmds_pkg::MODE_CODE_FORWARD, !out_r.switch_back && !out_r.led_back, "back side active in forward")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for throttle_motor_drive_sequencer_top.
// Depends on tmds_pkg and the top level; a class predicts each tick's drive status.
// Stimulus is directed band and arming cases, then random ticks under several limits.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmds_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned TICKS_PER_STEP = 195;
  localparam int unsigned SETTING_COUNT  = 8;

  // Drive status of one tick, in the order the out_ tdata carries it
  typedef struct packed {
    logic        led_front;
    logic        led_back;
    logic        sw_front;
    logic        sw_back;
    logic [1:0]  front_drv;
    logic [1:0]  back_drv;
    logic [11:0] duty;
    logic [11:0] duty_inv;
    logic [2:0]  mode;
  } drive_status_t;

  // Tracks sequencer, band flags and limits; predicts the status of every tick
  class tick_predictor;
    logic [10:0]   stop_limit = 11'd204;
    logic [11:0]   arm_limit  = 12'd2047;
    logic [2:0]    mode       = MODE_CODE_OFF;
    logic          stopped    = 1'b0;
    logic          full       = 1'b0;
    logic          rev_latch  = 1'b0;
    logic [11:0]   duty       = '0;
    logic [1:0]    lamps      = '0;
    logic [1:0]    mosfets    = '0;
    logic [1:0]    front_drv  = DRV_STOP;
    logic [1:0]    back_drv   = DRV_STOP;
    drive_status_t expected_status[$];
    int unsigned   errors, ticks, fwd_entries, rev_entries, full_events;

    function void set_limit(logic addr, logic [11:0] value);
      if (addr == CFG_STOP_LIMIT) stop_limit = value[10:0];
      else arm_limit = value;
    endfunction

    function void restart_arming();
      mode      = MODE_CODE_STARTING;
      lamps     = 2'b11;
      mosfets   = 2'b00;
      front_drv = DRV_STOP;
      back_drv  = DRV_STOP;
    endfunction

    function void note_tick(logic [11:0] t, logic rev);
      drive_status_t s;
      ticks++;
      // Band logic sees the latch and mode of the previous tick
      if (t < stop_limit) begin
        if (!stopped) begin
          stopped   = 1'b1;
          full      = 1'b0;
          front_drv = DRV_STOP;
          back_drv  = DRV_STOP;
        end
      end else if ((FULL_SCALE - t) < stop_limit) begin
        if (!full && (mode == MODE_CODE_FORWARD || mode == MODE_CODE_REVERSE)) begin
          full = 1'b1;
          full_events++;
          if (rev_latch) back_drv = DRV_FULL;
          else front_drv = DRV_FULL;
        end
      end else begin
        if (stopped || full) begin
          if (rev_latch) back_drv = DRV_MOD;
          else front_drv = DRV_MOD;
        end
        stopped = 1'b0;
        full    = 1'b0;
        duty    = t;
      end
      rev_latch = rev;
      // Sequencer moves on the new sample and latch
      case (mode)
        MODE_CODE_STARTING: begin
          mode  = (t < arm_limit) ? MODE_CODE_ARMED : MODE_CODE_BLINK;
          lamps = 2'b00;
        end
        MODE_CODE_BLINK: restart_arming();
        MODE_CODE_ARMED: begin
          if (rev_latch) begin
            mode      = MODE_CODE_REVERSE;
            lamps     = 2'b10;
            mosfets   = 2'b10;
            front_drv = DRV_STOP;
            back_drv  = DRV_MOD;
            rev_entries++;
          end else begin
            mode      = MODE_CODE_FORWARD;
            lamps     = 2'b01;
            mosfets   = 2'b01;
            back_drv  = DRV_STOP;
            front_drv = DRV_MOD;
            fwd_entries++;
          end
        end
        MODE_CODE_FORWARD: if (rev_latch) restart_arming();
        MODE_CODE_REVERSE: if (!rev_latch) restart_arming();
        default: restart_arming();
      endcase
      s.led_front = lamps[0];
      s.led_back  = lamps[1];
      s.sw_front  = mosfets[0];
      s.sw_back   = mosfets[1];
      s.front_drv = front_drv;
      s.back_drv  = back_drv;
      s.duty      = duty;
      s.duty_inv  = FULL_SCALE - duty;
      s.mode      = mode;
      expected_status.push_back(s);
    endfunction

    function void check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [39:0] d);
      drive_status_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: result with no tick pending, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      check_field("led_front", want.led_front, d[0]);
      check_field("led_back", want.led_back, d[1]);
      check_field("switch_front", want.sw_front, d[2]);
      check_field("switch_back", want.sw_back, d[3]);
      check_field("drive_front_mode", want.front_drv, d[5:4]);
      check_field("drive_back_mode", want.back_drv, d[7:6]);
      check_field("duty_level", want.duty, d[19:8]);
      check_field("duty_complement", want.duty_inv, d[31:20]);
      check_field("mode_now", want.mode, d[34:32]);
    endfunction
  endclass

  // Directed ticks as {reverse_switch, throttle_sample}, run under the reset limits
  localparam logic [12:0] DIRECTED_TICKS [22] = '{
    {1'b0, 12'd0},    {1'b0, 12'd100},  {1'b0, 12'd1000}, {1'b0, 12'd4095},
    {1'b0, 12'd4000}, {1'b0, 12'd2048}, {1'b0, 12'd0},    {1'b0, 12'd203},
    {1'b0, 12'd204},  {1'b0, 12'd3891}, {1'b0, 12'd3892}, {1'b1, 12'd2000},
    {1'b1, 12'd3000}, {1'b1, 12'd500},  {1'b1, 12'd2046}, {1'b1, 12'd2000},
    {1'b1, 12'd4095}, {1'b1, 12'd10},   {1'b0, 12'd1234}, {1'b0, 12'd2047},
    {1'b1, 12'd4095}, {1'b0, 12'd3}
  };

  logic        clk;
  logic        rst_n;
  logic [15:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_we;
  logic        cfg_addr;
  logic [11:0] cfg_wdata;

  tick_predictor sb;
  int unsigned   cycle_count;
  int unsigned   stall_left;
  int unsigned   stall_style;

  throttle_motor_drive_sequencer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Receiver: switch among stall styles at random, always-ready included
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (cycle_count % 3 != 0);
    endcase
  end

  // Monitor: check the result first so a stray one cannot match this edge's tick
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) sb.note_tick(in_tdata[11:0], in_tdata[12]);
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.expected_status.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one tick and hold it until the transfer
  task automatic send_tick(logic [11:0] t, logic rev);
    in_tdata  <= {3'b000, rev, t};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the stop limit, then the arm limit; the enable stays high between the writes
  task automatic write_limits(logic [10:0] stop_val, logic [11:0] arm_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_STOP_LIMIT;
    cfg_wdata <= {1'b0, stop_val};
    @(posedge clk);
    sb.set_limit(CFG_STOP_LIMIT, {1'b0, stop_val});
    cfg_addr  <= CFG_ARM_LIMIT;
    cfg_wdata <= arm_val;
    @(posedge clk);
    sb.set_limit(CFG_ARM_LIMIT, arm_val);
    cfg_we <= 1'b0;
  endtask

  // Random ticks in bursts; the reverse switch mostly holds a direction so the
  // sequencer gets through arming, with occasional flips and glitches as noise
  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int          lim;
    int          arm;
    int          t;
    logic        dir;
    logic        rev;
    sent = 0;
    dir  = 1'($urandom_range(0, 1));
    lim  = int'(sb.stop_limit);
    arm  = int'(sb.arm_limit);
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: t = $urandom_range(0, 4095);
          3:       t = lim + $urandom_range(0, 3) - 2;
          4:       t = 4095 - lim + $urandom_range(0, 3) - 2;
          5:       t = $urandom_range(0, 1) ? 4095 : 0;
          6:       t = (arm > 0) ? $urandom_range(0, arm - 1) : 0;
          7:       t = arm + $urandom_range(0, 2) - 1;
          default: t = (4095 - lim > lim) ? $urandom_range(lim, 4095 - lim)
                                         : $urandom_range(0, 4095);
        endcase
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        if ($urandom_range(0, 39) == 0) dir = ~dir;
        rev = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : dir;
        send_tick(t[11:0], rev);
        sent++;
      end
      // Sometimes run straight into the next burst, else drop valid for a gap
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_STOP_LIMIT;
    cfg_wdata   = '0;
    cycle_count = 0;
    stall_left  = 0;
    stall_style = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the band edges and every arming transition under the reset limits,
    // then run straight into the random ticks
    foreach (DIRECTED_TICKS[i]) send_tick(DIRECTED_TICKS[i][11:0], DIRECTED_TICKS[i][12]);
    run_random(TICKS_PER_STEP);

    // Sweep limit settings: extremes, an oversized stop band, random, then back to reset
    for (int unsigned step = 1; step < SETTING_COUNT; step++) begin
      wait_idle();
      case (step)
        1: write_limits(11'd0, 12'd4095);
        2: write_limits(11'd2047, 12'd0);
        3: write_limits(11'd2047, 12'd4095);
        4: write_limits(11'd1, 12'd1);
        7: write_limits(11'd204, 12'd2047);
        default: write_limits(11'($urandom_range(0, 2047)), 12'($urandom_range(0, 4095)));
      endcase
      run_random(TICKS_PER_STEP);
    end

    wait_idle();
    $display("Checked %0d ticks over %0d limit settings with random stalls on both sides.",
             sb.ticks, SETTING_COUNT);
    $display("Forward entries %0d, reverse entries %0d, full-on events %0d, mismatches %0d.",
             sb.fwd_entries, sb.rev_entries, sb.full_events, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
